// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Screen geometry, derived widths, command and character codes, and the
// classified request that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = COLUMNS * ROWS;

  // Widths of the console fields, fixed by the interface.
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int COUNT_W = 11;
  localparam int POS_W   = 11;

  localparam int AW  = $clog2(CELLS);
  localparam int CNW = $clog2(CELLS + 1);
  // The cursor may run past the last cell by up to one newline or one tab.
  localparam int CMAX = CELLS + COLUMNS + TAB_STOP;
  localparam int CW   = $clog2(CMAX + 1);
  // Largest linear position that a row and column field can address.
  localparam int LINMAX = ((1 << ROW_W) - 1) * COLUMNS + ((1 << COL_W) - 1);
  localparam int MW     = $clog2(((LINMAX > CMAX) ? LINMAX : CMAX) + 1);
  localparam int XW0    = (CW > CNW) ? CW : CNW;
  localparam int XW     = ((XW0 > COUNT_W) ? XW0 : COUNT_W) + 1;
  localparam int TSW    = $clog2(TAB_STOP + 1);

  // Reciprocal of COLUMNS for the cursor's row split; exact for every
  // cursor value below CELLS.
  localparam int RECIP_SH  = 17;
  localparam int COL_RECIP = ((1 << RECIP_SH) + COLUMNS - 1) / COLUMNS;
  localparam int RECIP_W   = $clog2(COL_RECIP + 1);
  localparam int PW        = CW + RECIP_W;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PLACE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;

  typedef enum logic [2:0] {
    K_CHAR,
    K_NEWLINE,
    K_RETURN,
    K_TAB,
    K_PLACE,
    K_ERASE,
    K_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [CHAR_W-1:0]   ch;
    logic                start;
    logic [MW-1:0]       lin;
    logic                in_range;
    logic [COUNT_W-1:0]  back;
    logic [COUNT_W-1:0]  clr;
  } op_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front: request intake and classification
// Decodes each request into an operation kind, computes the linear cell
// position, and holds the result in a short queue for the back end.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]     in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::COL_W-1:0]     in_column,
  input  logic [tcw_pkg::ROW_W-1:0]     in_row,
  input  logic                          in_string_start,
  input  logic [tcw_pkg::COUNT_W-1:0]   in_backtrack,
  input  logic [tcw_pkg::COUNT_W-1:0]   in_clear_count,
  input  tcw_pkg::back_status_t         status,
  output logic                          q_valid,
  output tcw_pkg::op_t                  q_head
);

  tcw_pkg::op_t             q_r [tcw_pkg::QDEPTH];
  logic [tcw_pkg::QPW-1:0]  wp_r, wp_nxt;
  logic [tcw_pkg::QPW-1:0]  rp_r, rp_nxt;
  logic [tcw_pkg::QCW-1:0]  cnt_r, cnt_nxt;
  tcw_pkg::op_t             op;
  logic                     push;

  always_comb begin
    op.ch       = in_char_code;
    op.start    = in_string_start;
    op.back     = in_backtrack;
    op.clr      = in_clear_count;
    op.lin      = tcw_pkg::MW'(in_row) * tcw_pkg::MW'(tcw_pkg::COLUMNS)
                  + tcw_pkg::MW'(in_column);
    op.in_range = (32'(in_column) < tcw_pkg::COLUMNS) && (32'(in_row) < tcw_pkg::ROWS);
    case (in_command)
      tcw_pkg::CMD_PUT: begin
        case (in_char_code)
          tcw_pkg::CH_NEWLINE: op.kind = tcw_pkg::K_NEWLINE;
          tcw_pkg::CH_RETURN:  op.kind = tcw_pkg::K_RETURN;
          tcw_pkg::CH_TAB:     op.kind = tcw_pkg::K_TAB;
          default:             op.kind = tcw_pkg::K_CHAR;
        endcase
      end
      tcw_pkg::CMD_PLACE: op.kind = tcw_pkg::K_PLACE;
      tcw_pkg::CMD_ERASE: op.kind = tcw_pkg::K_ERASE;
      default:            op.kind = tcw_pkg::K_READ;
    endcase
  end

  // Intake is held off during the power-on screen clear.
  assign in_stall = (cnt_r == tcw_pkg::QCW'(tcw_pkg::QDEPTH)) || status.clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == tcw_pkg::QPW'(tcw_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (status.pop) begin
      rp_nxt = (rp_r == tcw_pkg::QPW'(tcw_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !status.pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && status.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= op;
    end
  end

endmodule

// ===== hw/rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back: operation sequencer
// Carries out queued operations on the screen memory: character writes,
// cursor moves, scrolling, blanking runs and cell reads, then registers
// one result per request.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  tcw_pkg::op_t                 q_head,
  output tcw_pkg::back_status_t        status,
  output logic                         ram_we,
  output logic [tcw_pkg::AW-1:0]       ram_waddr,
  output logic [tcw_pkg::CHAR_W-1:0]   ram_wdata,
  output logic [tcw_pkg::AW-1:0]       ram_raddr,
  input  logic [tcw_pkg::CHAR_W-1:0]   ram_rdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcw_pkg::POS_W-1:0]    out_cursor_pos,
  output logic [tcw_pkg::CHAR_W-1:0]   out_cell_char
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD_DONE,
    ST_SETTLE,
    ST_SCROLL,
    ST_SCR_FLUSH,
    ST_BLANK,
    ST_ER1,
    ST_ER2,
    ST_READ_WT,
    ST_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [tcw_pkg::CW-1:0]       cursor_r, cursor_nxt;
  logic [tcw_pkg::AW-1:0]       pp_r, pp_nxt;
  tcw_pkg::op_t                 cur_r, cur_nxt;
  logic [tcw_pkg::MW-1:0]       rem_r, rem_nxt;
  logic [tcw_pkg::TSW-1:0]      step_r, step_nxt;
  logic                         tab_pend_r, tab_pend_nxt;
  logic [tcw_pkg::AW-1:0]       bl_addr_r, bl_addr_nxt;
  logic [tcw_pkg::CNW-1:0]      bl_cnt_r, bl_cnt_nxt;
  logic                         ret_settle_r, ret_settle_nxt;
  logic [tcw_pkg::AW-1:0]       sc_r, sc_nxt;
  logic                         pend_v_r, pend_v_nxt;
  logic [tcw_pkg::AW-1:0]       pend_addr_r, pend_addr_nxt;
  logic [tcw_pkg::CHAR_W-1:0]   read_val_r, read_val_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [tcw_pkg::POS_W-1:0]    out_cursor_r, out_cursor_nxt;
  logic [tcw_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;

  logic [tcw_pkg::PW-1:0]       col_prod;
  logic [tcw_pkg::CW-1:0]       col_quot;
  logic [tcw_pkg::CW-1:0]       col_rem;
  logic [tcw_pkg::CNW-1:0]      tab_cnt;
  logic [tcw_pkg::CNW-1:0]      room;
  logic [tcw_pkg::AW-1:0]       rem_addr;

  // Column of the cursor by reciprocal multiplication; the cursor is always
  // below CELLS when a request is taken.
  assign col_prod = tcw_pkg::PW'(cursor_r) * tcw_pkg::PW'(tcw_pkg::COL_RECIP);
  assign col_quot = tcw_pkg::CW'(col_prod >> tcw_pkg::RECIP_SH);
  assign col_rem  = cursor_r - col_quot * tcw_pkg::CW'(tcw_pkg::COLUMNS);
  assign tab_cnt  = (tcw_pkg::XW'(cursor_r) < tcw_pkg::XW'(step_r))
                    ? tcw_pkg::CNW'(cursor_r) : tcw_pkg::CNW'(step_r);
  assign room     = tcw_pkg::CNW'(tcw_pkg::CELLS) - tcw_pkg::CNW'(cursor_r);
  assign rem_addr = tcw_pkg::AW'(rem_r);

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    pp_nxt         = pp_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    tab_pend_nxt   = tab_pend_r;
    bl_addr_nxt    = bl_addr_r;
    bl_cnt_nxt     = bl_cnt_r;
    ret_settle_nxt = ret_settle_r;
    sc_nxt         = sc_r;
    pend_v_nxt     = pend_v_r;
    pend_addr_nxt  = pend_addr_r;
    read_val_nxt   = read_val_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_cursor_nxt = out_cursor_r;
    out_char_nxt   = out_char_r;
    status.pop      = 1'b0;
    status.clearing = (state_r == ST_CLEAR);
    ram_we    = 1'b0;
    ram_waddr = bl_addr_r;
    ram_wdata = tcw_pkg::CH_BLANK;
    ram_raddr = sc_r;

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        bl_addr_nxt = bl_addr_r + 1'b1;
        bl_cnt_nxt  = bl_cnt_r - 1'b1;
        if (bl_cnt_r == tcw_pkg::CNW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (q_valid) begin
          status.pop   = 1'b1;
          cur_nxt      = q_head;
          read_val_nxt = '0;
          case (q_head.kind)
            tcw_pkg::K_CHAR: begin
              ram_we     = 1'b1;
              ram_waddr  = tcw_pkg::AW'(cursor_r);
              ram_wdata  = q_head.ch;
              cursor_nxt = cursor_r + 1'b1;
              state_nxt  = ST_SETTLE;
            end
            tcw_pkg::K_NEWLINE, tcw_pkg::K_RETURN: begin
              rem_nxt   = tcw_pkg::MW'(col_rem);
              state_nxt = ST_MOD_DONE;
            end
            tcw_pkg::K_TAB: begin
              rem_nxt   = tcw_pkg::MW'(cursor_r % tcw_pkg::CW'(tcw_pkg::TAB_STOP));
              state_nxt = ST_MOD_DONE;
            end
            tcw_pkg::K_PLACE: begin
              if (q_head.start) begin
                // A start position never reaches twice the cell count.
                rem_nxt   = (q_head.lin >= tcw_pkg::MW'(tcw_pkg::CELLS))
                            ? q_head.lin - tcw_pkg::MW'(tcw_pkg::CELLS) : q_head.lin;
                state_nxt = ST_MOD_DONE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pp_r;
                ram_wdata = q_head.ch;
                pp_nxt    = (pp_r == tcw_pkg::AW'(tcw_pkg::CELLS - 1)) ? '0 : pp_r + 1'b1;
                state_nxt = ST_DONE;
              end
            end
            tcw_pkg::K_ERASE: begin
              state_nxt = ST_ER1;
            end
            default: begin
              if (q_head.in_range) begin
                ram_raddr = tcw_pkg::AW'(q_head.lin);
                state_nxt = ST_READ_WT;
              end else begin
                state_nxt = ST_DONE;
              end
            end
          endcase
        end
      end

      ST_MOD_DONE: begin
        case (cur_r.kind)
          tcw_pkg::K_NEWLINE: begin
            cursor_nxt = cursor_r + tcw_pkg::CW'(tcw_pkg::COLUMNS) - tcw_pkg::CW'(rem_r);
            state_nxt  = ST_SETTLE;
          end
          tcw_pkg::K_RETURN: begin
            cursor_nxt = cursor_r - tcw_pkg::CW'(rem_r);
            state_nxt  = ST_DONE;
          end
          tcw_pkg::K_TAB: begin
            step_nxt     = tcw_pkg::TSW'(tcw_pkg::TAB_STOP) - tcw_pkg::TSW'(rem_r);
            cursor_nxt   = cursor_r + tcw_pkg::CW'(tcw_pkg::TAB_STOP)
                           - tcw_pkg::CW'(rem_r);
            tab_pend_nxt = 1'b1;
            state_nxt    = ST_SETTLE;
          end
          tcw_pkg::K_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = rem_addr;
            ram_wdata = cur_r.ch;
            pp_nxt    = (rem_addr == tcw_pkg::AW'(tcw_pkg::CELLS - 1)) ? '0
                        : rem_addr + 1'b1;
            state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_SETTLE: begin
        if (cursor_r >= tcw_pkg::CW'(tcw_pkg::CELLS)) begin
          cursor_nxt = cursor_r - tcw_pkg::CW'(tcw_pkg::COLUMNS);
          sc_nxt     = tcw_pkg::AW'(tcw_pkg::COLUMNS);
          pend_v_nxt = 1'b0;
          state_nxt  = ST_SCROLL;
        end else if (tab_pend_r) begin
          // Blank the cells the tab skipped, never below cell zero.
          tab_pend_nxt   = 1'b0;
          bl_addr_nxt    = tcw_pkg::AW'(cursor_r) - tcw_pkg::AW'(tab_cnt);
          bl_cnt_nxt     = tab_cnt;
          ret_settle_nxt = 1'b0;
          state_nxt      = ST_BLANK;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // Each cell is read one row below its target and written in the cycle after its read.
      ST_SCROLL: begin
        ram_raddr     = sc_r;
        ram_we        = pend_v_r;
        ram_waddr     = pend_addr_r;
        ram_wdata     = ram_rdata;
        pend_v_nxt    = 1'b1;
        pend_addr_nxt = sc_r - tcw_pkg::AW'(tcw_pkg::COLUMNS);
        if (sc_r == tcw_pkg::AW'(tcw_pkg::CELLS - 1)) begin
          state_nxt = ST_SCR_FLUSH;
        end else begin
          sc_nxt = sc_r + 1'b1;
        end
      end

      ST_SCR_FLUSH: begin
        ram_we         = 1'b1;
        ram_waddr      = pend_addr_r;
        ram_wdata      = ram_rdata;
        pend_v_nxt     = 1'b0;
        bl_addr_nxt    = tcw_pkg::AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
        bl_cnt_nxt     = tcw_pkg::CNW'(tcw_pkg::COLUMNS);
        ret_settle_nxt = 1'b1;
        state_nxt      = ST_BLANK;
      end

      ST_BLANK: begin
        if (bl_cnt_r == '0) begin
          state_nxt = ret_settle_r ? ST_SETTLE : ST_DONE;
        end else begin
          ram_we      = 1'b1;
          bl_addr_nxt = bl_addr_r + 1'b1;
          bl_cnt_nxt  = bl_cnt_r - 1'b1;
          if (bl_cnt_r == tcw_pkg::CNW'(1)) begin
            state_nxt = ret_settle_r ? ST_SETTLE : ST_DONE;
          end
        end
      end

      ST_ER1: begin
        if (tcw_pkg::XW'(cursor_r) > tcw_pkg::XW'(cur_r.back)) begin
          cursor_nxt = cursor_r - tcw_pkg::CW'(cur_r.back);
        end else begin
          cursor_nxt = '0;
        end
        state_nxt = ST_ER2;
      end

      ST_ER2: begin
        bl_addr_nxt    = tcw_pkg::AW'(cursor_r);
        bl_cnt_nxt     = (tcw_pkg::XW'(cur_r.clr) > tcw_pkg::XW'(room))
                         ? room : tcw_pkg::CNW'(cur_r.clr);
        ret_settle_nxt = 1'b0;
        state_nxt      = ST_BLANK;
      end

      ST_READ_WT: begin
        read_val_nxt = ram_rdata;
        state_nxt    = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_cursor_nxt = tcw_pkg::POS_W'(cursor_r);
          out_char_nxt   = read_val_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cursor_r    <= '0;
      pp_r        <= '0;
      tab_pend_r  <= 1'b0;
      pend_v_r    <= 1'b0;
      bl_addr_r   <= '0;
      bl_cnt_r    <= tcw_pkg::CNW'(tcw_pkg::CELLS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      pp_r        <= pp_nxt;
      tab_pend_r  <= tab_pend_nxt;
      pend_v_r    <= pend_v_nxt;
      bl_addr_r   <= bl_addr_nxt;
      bl_cnt_r    <= bl_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    ret_settle_r <= ret_settle_nxt;
    sc_r         <= sc_nxt;
    pend_addr_r  <= pend_addr_nxt;
    read_val_r   <= read_val_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_char_r   <= out_char_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_cursor_r;
  assign out_cell_char  = out_char_r;

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer: character screen writer with cursor
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  command, char_code, column, row,
//                                          string_start, backtrack, clear_count
//   out      output     out_valid/out_stall cursor_pos, cell_char
//
// From queue head to result register: a place that continues a string is
// written at once; a character, a newline and a tab then settle the cursor,
// and a tab blanks the cells it skipped; a read waits for its registered
// data; an erase moves the cursor back and blanks a run. A scroll moves each
// cell up a row through the single write port, then blanks the bottom row.
// After reset a clearing pass writes spaces to all COLUMNS*ROWS cells, one per
// cycle, and in_stall stays high until it ends.
// A two-entry queue keeps intake going while the sequencer works or out_stall
// holds a finished result.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]    in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::COL_W-1:0]    in_column,
  input  logic [tcw_pkg::ROW_W-1:0]    in_row,
  input  logic                         in_string_start,
  input  logic [tcw_pkg::COUNT_W-1:0]  in_backtrack,
  input  logic [tcw_pkg::COUNT_W-1:0]  in_clear_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcw_pkg::POS_W-1:0]    out_cursor_pos,
  output logic [tcw_pkg::CHAR_W-1:0]   out_cell_char
);

  tcw_pkg::back_status_t       status;
  tcw_pkg::op_t                q_head;
  logic                        q_valid;
  logic                        ram_we;
  logic [tcw_pkg::AW-1:0]      ram_waddr;
  logic [tcw_pkg::CHAR_W-1:0]  ram_wdata;
  logic [tcw_pkg::AW-1:0]      ram_raddr;
  logic [tcw_pkg::CHAR_W-1:0]  ram_rdata;

  tcw_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_char_code    (in_char_code),
    .in_column       (in_column),
    .in_row          (in_row),
    .in_string_start (in_string_start),
    .in_backtrack    (in_backtrack),
    .in_clear_count  (in_clear_count),
    .status          (status),
    .q_valid         (q_valid),
    .q_head          (q_head)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CHAR_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .status         (status),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_char  (out_cell_char)
  );

endmodule
